[hdl/owrs_pkg.sv]
// ----------------------------------------------------------------------------
// owrs_pkg
// Shared types, codes and helpers for the 1-Wire ROM search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package owrs_pkg;

	localparam int ID_BITS   = 64;
	localparam int IDX_W     = $clog2(ID_BITS);
	localparam int BIT_W     = 7;
	localparam int CNT_W     = 8;
	localparam int RETRY_W   = 2;

	localparam logic [RETRY_W-1:0] MAX_RETRIES = RETRY_W'(3);
	localparam logic [CNT_W-1:0]   MAX_DEV_RST = CNT_W'(16);

	localparam logic [1:0] OP_BEGIN    = 2'd0;
	localparam logic [1:0] OP_PRESENCE = 2'd1;
	localparam logic [1:0] OP_TRIPLET  = 2'd2;

	typedef enum logic [2:0] {
		ST_NEXT_BIT   = 3'd0,
		ST_START_PASS = 3'd1,
		ST_FOUND      = 3'd2,
		ST_FINISHED   = 3'd3,
		ST_NO_PRES    = 3'd4,
		ST_CONFLICTS  = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       presence;
		logic       id_bit;
		logic       complement_bit;
		logic       taken_direction;
	} item_t;

	typedef struct packed {
		status_t              status;
		logic                 direction;
		logic [BIT_W-1:0]     bit_index;
		logic [ID_BITS-1:0]   device_id;
		logic [CNT_W-1:0]     device_count;
		logic                 search_over;
	} result_t;

	// Direction to send for one-based bit bitno, given the last discrepancy.
	function automatic logic dir_for(input logic [BIT_W-1:0] bitno,
	                                 input logic [BIT_W-1:0] last_disc,
	                                 input logic [ID_BITS-1:0] last_id);
		logic [IDX_W-1:0] idx;
		logic             d;
		idx = IDX_W'(bitno - BIT_W'(1));
		if (bitno == '0)
			d = 1'b0;
		else if (bitno < last_disc)
			d = last_id[idx];
		else if (bitno == last_disc)
			d = 1'b1;
		else
			d = 1'b0;
		return d;
	endfunction

endpackage

`default_nettype wire

[hdl/one_wire_rom_search_unit.sv]
// Path: a transaction is captured in the input register, updated in the core and
// then held in the result register until the receiver takes it.
// Throughput: one transaction per cycle unless out_stall holds the output;
// input register, one update stage, output register, with the search state updated in the single stage.
// Reset: asynchronous, active low; search idle and finished, device limit 16.
// ----------------------------------------------------------------------------
// one_wire_rom_search_unit
// 1-Wire ROM search sequencer: per-event direction, ID capture and bookkeeping.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_rom_search_unit
	import owrs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               cfg_we,
	input  wire logic [CNT_W-1:0]   cfg_wdata,

	input  wire logic               in_valid,
	output      logic               in_stall,
	input  wire logic [1:0]         opcode,
	input  wire logic               presence,
	input  wire logic               id_bit,
	input  wire logic               complement_bit,
	input  wire logic               taken_direction,

	output      logic               out_valid,
	input  wire logic               out_stall,
	output      logic [2:0]         status,
	output      logic               direction,
	output      logic [BIT_W-1:0]   bit_index,
	output      logic [ID_BITS-1:0] device_id,
	output      logic [CNT_W-1:0]   device_count,
	output      logic               search_over
);

	logic [CNT_W-1:0] max_dev_q;
	item_t            item_s1;
	logic             valid_s1;
	result_t          res;
	result_t          res_q;
	logic             out_valid_q;
	logic             step_en;
	logic             in_take;

	// update when the output register is free or being emptied
	assign step_en  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !step_en;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_dev_q <= MAX_DEV_RST;
		else if (cfg_we)
			max_dev_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take)
				valid_s1 <= 1'b1;
			else if (step_en)
				valid_s1 <= 1'b0;
			if (step_en)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.opcode          <= opcode;
			item_s1.presence        <= presence;
			item_s1.id_bit          <= id_bit;
			item_s1.complement_bit  <= complement_bit;
			item_s1.taken_direction <= taken_direction;
		end
		if (step_en)
			res_q <= res;
	end

	owrs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.item      (item_s1),
		.dev_limit (max_dev_q),
		.result    (res)
	);

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign direction    = res_q.direction;
	assign bit_index    = res_q.bit_index;
	assign device_id    = res_q.device_id;
	assign device_count = res_q.device_count;
	assign search_over  = res_q.search_over;

endmodule

`default_nettype wire

[hdl/owrs_core.sv]
// ----------------------------------------------------------------------------
// owrs_core
// Search state and combinational event update; gives the result of the event.
// ----------------------------------------------------------------------------
`default_nettype none

module owrs_core
	import owrs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step_en,
	input  wire item_t            item,
	input  wire logic [CNT_W-1:0] dev_limit,
	output      result_t          result
);

	logic [ID_BITS-1:0] prev_id_q,   prev_id_n;
	logic [BIT_W-1:0]   prev_disc_q, prev_disc_n;
	logic [BIT_W-1:0]   pass_disc_q, pass_disc_n;
	logic [BIT_W-1:0]   bit_q,       bit_n;
	logic [ID_BITS-1:0] acc_q,       acc_n;
	logic [RETRY_W-1:0] retry_q,     retry_n;
	logic [CNT_W-1:0]   found_q,     found_n;
	logic               fin_q,       fin_n;

	status_t            status;
	logic [ID_BITS-1:0] rom;
	logic [ID_BITS-1:0] acc_set;
	logic [IDX_W-1:0]   bidx;
	logic               sent;

	always_comb begin
		prev_id_n   = prev_id_q;
		prev_disc_n = prev_disc_q;
		pass_disc_n = pass_disc_q;
		bit_n       = bit_q;
		acc_n       = acc_q;
		retry_n     = retry_q;
		found_n     = found_q;
		fin_n       = fin_q;
		status      = ST_NEXT_BIT;
		rom         = '0;
		sent        = dir_for(bit_q, prev_disc_q, prev_id_q);
		bidx        = IDX_W'(bit_q - BIT_W'(1));
		acc_set     = acc_q;
		if (bit_q >= BIT_W'(1) && bit_q <= BIT_W'(ID_BITS))
			acc_set[bidx] = acc_q[bidx] | item.taken_direction;

		case (item.opcode)
			OP_BEGIN: begin
				prev_id_n   = '0;
				prev_disc_n = '0;
				retry_n     = '0;
				found_n     = '0;
				acc_n       = '0;
				pass_disc_n = '0;
				bit_n       = BIT_W'(1);
				if (dev_limit == '0) begin
					fin_n  = 1'b1;
					status = ST_FINISHED;
				end else begin
					fin_n  = 1'b0;
					status = ST_START_PASS;
				end
			end
			OP_PRESENCE: begin
				if (fin_q) begin
					status = ST_FINISHED;
				end else begin
					acc_n       = '0;
					pass_disc_n = '0;
					bit_n       = BIT_W'(1);
					if (!item.presence) begin
						fin_n  = 1'b1;
						status = ST_NO_PRES;
					end
				end
			end
			OP_TRIPLET: begin
				if (fin_q) begin
					status = ST_FINISHED;
				end else if (item.id_bit && item.complement_bit) begin
					// both bits high: abort pass, count a retry
					acc_n       = '0;
					pass_disc_n = '0;
					bit_n       = BIT_W'(1);
					retry_n     = retry_q + RETRY_W'(1);
					if (retry_n >= MAX_RETRIES) begin
						fin_n  = 1'b1;
						status = ST_CONFLICTS;
					end else begin
						status = ST_START_PASS;
					end
				end else begin
					if (!item.id_bit && !item.complement_bit && !sent)
						pass_disc_n = bit_q;
					if (bit_q >= BIT_W'(ID_BITS)) begin
						rom     = acc_set;
						found_n = found_q + CNT_W'(1);
						retry_n = '0;
						status  = ST_FOUND;
						if (pass_disc_n == '0 || found_n >= dev_limit) begin
							fin_n = 1'b1;
						end else begin
							prev_disc_n = pass_disc_n;
							prev_id_n   = acc_set;
						end
						acc_n       = '0;
						pass_disc_n = '0;
						bit_n       = BIT_W'(1);
					end else begin
						acc_n = acc_set;
						bit_n = bit_q + BIT_W'(1);
					end
				end
			end
			default: begin
				status = fin_q ? ST_FINISHED : ST_NEXT_BIT;
			end
		endcase

		if (fin_n)
			bit_n = BIT_W'(1);

		result.status       = status;
		result.direction    = fin_n ? 1'b0 : dir_for(bit_n, prev_disc_n, prev_id_n);
		result.bit_index    = bit_n;
		result.device_id    = rom;
		result.device_count = found_n;
		result.search_over  = fin_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_id_q   <= '0;
			prev_disc_q <= '0;
			pass_disc_q <= '0;
			bit_q       <= BIT_W'(1);
			acc_q       <= '0;
			retry_q     <= '0;
			found_q     <= '0;
			fin_q       <= 1'b1;
		end else if (step_en) begin
			prev_id_q   <= prev_id_n;
			prev_disc_q <= prev_disc_n;
			pass_disc_q <= pass_disc_n;
			bit_q       <= bit_n;
			acc_q       <= acc_n;
			retry_q     <= retry_n;
			found_q     <= found_n;
			fin_q       <= fin_n;
		end
	end

endmodule

`default_nettype wire

[test/one_wire_rom_search_unit_tb.sv]
// ----------------------------------------------------------------------------
// one_wire_rom_search_unit_tb
// Self-checking bench for the 1-Wire ROM search sequencer. A bus model of a
// few devices answers each triplet by wired-AND, so that whole searches run
// through the block; directed events cover idle, limit and conflict handling,
// and a noisy phase feeds broken sequences. Every result is compared with a
// predictor of the search state, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module one_wire_rom_search_unit_tb;
	import owrs_pkg::*;

	localparam logic [1:0] OP_UNDEFINED  = 2'd3;
	localparam int         RUN_LIMIT     = 500000;
	localparam int         DRAIN_CYCLES  = 6;
	localparam int         SEARCH_TARGET = 900;
	localparam int         PRINT_CAP     = 40;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CNT_W-1:0]   cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         opcode = OP_BEGIN;
	logic               presence = 1'b0;
	logic               id_bit = 1'b0;
	logic               complement_bit = 1'b0;
	logic               taken_direction = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         status;
	logic               direction;
	logic [BIT_W-1:0]   bit_index;
	logic [ID_BITS-1:0] device_id;
	logic [CNT_W-1:0]   device_count;
	logic               search_over;

	// predictor copy of the search state
	logic [CNT_W-1:0]   max_dev = MAX_DEV_RST;
	logic [ID_BITS-1:0] fork_id = '0;
	logic [BIT_W-1:0]   last_fork = '0;
	logic [BIT_W-1:0]   pass_fork = '0;
	logic [BIT_W-1:0]   next_bit = 7'd1;
	logic [ID_BITS-1:0] rom_acc = '0;
	logic [RETRY_W-1:0] retries = '0;
	logic [CNT_W-1:0]   found = '0;
	logic               done = 1'b1;

	result_t            search_results[$];
	result_t            last_expect = '{status: ST_FINISHED, search_over: 1'b1, default: '0};
	logic [ID_BITS-1:0] bus_ids[$];

	int  cycles = 0;
	int  mismatches = 0;
	int  events_sent = 0;
	int  stall_left = 0;
	bit  feed_gaps = 1'b1;
	bit  sink_stalls = 1'b1;

	one_wire_rom_search_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.presence        (presence),
		.id_bit          (id_bit),
		.complement_bit  (complement_bit),
		.taken_direction (taken_direction),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.direction       (direction),
		.bit_index       (bit_index),
		.device_id       (device_id),
		.device_count    (device_count),
		.search_over     (search_over)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= RUN_LIMIT) begin
			$display("FAIL one_wire_rom_search_unit");
			$finish;
		end
	end

	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	// mostly short pauses, now and then a long one
	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 92)
			return $urandom_range(4, 8);
		return $urandom_range(12, 40);
	endfunction

	// receiver stalls; both idling modes switch on and off in stretches
	always @(negedge clk) begin
		if (cycles % 400 == 0) begin
			feed_gaps = $urandom_range(0, 3) != 0;
			sink_stalls = $urandom_range(0, 3) != 0;
		end
		if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
			out_stall = 1'b1;
			stall_left = pick_pause() - 1;
		end else begin
			out_stall = 1'b0;
		end
	end

	function automatic item_t make_event(input logic [1:0] op, input logic pres,
	                                     input logic idb, input logic cmp,
	                                     input logic took);
		item_t ev;
		ev.opcode = op;
		ev.presence = pres;
		ev.id_bit = idb;
		ev.complement_bit = cmp;
		ev.taken_direction = took;
		return ev;
	endfunction

	// branch to send for a one-based bit, following the last zero fork
	function automatic logic branch_for(input logic [BIT_W-1:0] bitno);
		logic [5:0] pos;
		pos = 6'(bitno - 7'd1);
		if (bitno == '0)
			return 1'b0;
		if (bitno < last_fork)
			return fork_id[pos];
		if (bitno == last_fork)
			return 1'b1;
		return 1'b0;
	endfunction

	function automatic void restart_pass();
		rom_acc = '0;
		pass_fork = '0;
		next_bit = 7'd1;
	endfunction

	task automatic predict_search(input item_t ev);
		result_t          r;
		logic [BIT_W-1:0] b;
		logic             sent;
		r = '0;
		b = next_bit;
		case (ev.opcode)
			OP_BEGIN: begin
				fork_id = '0;
				last_fork = '0;
				retries = '0;
				found = '0;
				restart_pass();
				if (max_dev == '0) begin
					done = 1'b1;
					r.status = ST_FINISHED;
				end else begin
					done = 1'b0;
					r.status = ST_START_PASS;
				end
			end
			OP_PRESENCE: begin
				if (done) begin
					r.status = ST_FINISHED;
				end else begin
					restart_pass();
					if (!ev.presence) begin
						done = 1'b1;
						r.status = ST_NO_PRES;
					end else begin
						r.status = ST_NEXT_BIT;
					end
				end
			end
			OP_TRIPLET: begin
				if (done) begin
					r.status = ST_FINISHED;
				end else if (ev.id_bit && ev.complement_bit) begin
					// nobody answered both slots: abort and maybe retry
					restart_pass();
					retries = retries + 2'd1;
					if (retries >= MAX_RETRIES) begin
						done = 1'b1;
						r.status = ST_CONFLICTS;
					end else begin
						r.status = ST_START_PASS;
					end
				end else begin
					sent = branch_for(b);
					if (!ev.id_bit && !ev.complement_bit && !sent)
						pass_fork = b;
					rom_acc = rom_acc | (64'(ev.taken_direction) << (b - 7'd1));
					if (b >= ID_BITS) begin
						r.device_id = rom_acc;
						found = found + 8'd1;
						retries = '0;
						r.status = ST_FOUND;
						if (pass_fork == '0 || found >= max_dev) begin
							done = 1'b1;
						end else begin
							last_fork = pass_fork;
							fork_id = rom_acc;
						end
						restart_pass();
					end else begin
						next_bit = b + 7'd1;
						r.status = ST_NEXT_BIT;
					end
				end
			end
			default: begin
				r.status = done ? ST_FINISHED : ST_NEXT_BIT;
			end
		endcase
		if (done)
			next_bit = 7'd1;
		r.direction = done ? 1'b0 : branch_for(next_bit);
		r.bit_index = next_bit;
		r.device_count = found;
		r.search_over = done;
		search_results.push_back(r);
		last_expect = r;
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] got,
	                               input logic [63:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch %s: got %h want %h at cycle %0d", field, got, want, cycles);
	endtask

	always @(posedge clk) begin : check_results
		result_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (search_results.size() == 0) begin
				report_mismatch("unexpected result, status", 64'(status), '0);
			end else begin
				due = search_results.pop_front();
				if (status !== due.status)
					report_mismatch("status", 64'(status), 64'(due.status));
				if (direction !== due.direction)
					report_mismatch("direction", 64'(direction), 64'(due.direction));
				if (bit_index !== due.bit_index)
					report_mismatch("bit_index", 64'(bit_index), 64'(due.bit_index));
				if (device_id !== due.device_id)
					report_mismatch("device_id", device_id, due.device_id);
				if (device_count !== due.device_count)
					report_mismatch("device_count", 64'(device_count), 64'(due.device_count));
				if (search_over !== due.search_over)
					report_mismatch("search_over", 64'(search_over), 64'(due.search_over));
			end
		end
	end

	// valid stays high on return, so a following event goes back to back
	task automatic send_event(input item_t ev);
		int gap;
		gap = (feed_gaps && $urandom_range(0, 2) == 0) ? pick_pause() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		opcode = ev.opcode;
		presence = ev.presence;
		id_bit = ev.id_bit;
		complement_bit = ev.complement_bit;
		taken_direction = ev.taken_direction;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_search(ev);
		events_sent++;
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		in_valid = 1'b0;
		while (search_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [CNT_W-1:0] value);
		wait_quiet();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		max_dev = value;
	endtask

	// devices close to one base ID, so the tree has plenty of forks
	function automatic void load_bus(input int n);
		logic [63:0] d;
		logic [63:0] base;
		int          idx;
		base = {$urandom, $urandom};
		bus_ids.delete();
		repeat (n) begin
			d = base;
			repeat ($urandom_range(1, 4)) begin
				idx = $urandom_range(0, 63);
				d[idx] = ~d[idx];
			end
			bus_ids.push_back(d);
		end
	endfunction

	// one pass on the bus model: reset, then triplets until the pass ends
	task automatic run_pass(input int conflict_pct);
		bit         alive[$];
		int         jam_bit;
		logic [5:0] pos;
		logic       any0;
		logic       any1;
		logic       idb;
		logic       cmp;
		logic       took;
		jam_bit = ($urandom_range(0, 99) < conflict_pct) ? $urandom_range(1, 64) : 0;
		if ($urandom_range(0, 49) == 0) begin
			send_event(make_event(OP_PRESENCE, 1'b0, coin(), coin(), coin()));
			return;
		end
		send_event(make_event(OP_PRESENCE, 1'b1, coin(), coin(), coin()));
		foreach (bus_ids[i])
			alive.push_back(1'b1);
		while (last_expect.status == ST_NEXT_BIT && !last_expect.search_over) begin
			pos = 6'(last_expect.bit_index - 7'd1);
			any0 = 1'b0;
			any1 = 1'b0;
			foreach (bus_ids[i]) begin
				if (alive[i]) begin
					if (bus_ids[i][pos])
						any1 = 1'b1;
					else
						any0 = 1'b0 | 1'b1;
				end
			end
			// wired-AND: a slot reads 1 only if no live device pulls it low
			idb = !any0;
			cmp = !any1;
			if (last_expect.bit_index == jam_bit) begin
				idb = 1'b1;
				cmp = 1'b1;
			end
			if (idb && cmp)
				took = coin();
			else if (idb != cmp)
				took = idb;
			else
				took = last_expect.direction;
			send_event(make_event(OP_TRIPLET, coin(), idb, cmp, took));
			foreach (bus_ids[i])
				if (bus_ids[i][pos] != took)
					alive[i] = 1'b0;
		end
	endtask

	task automatic search_passes(input int conflict_pct, input int pass_cap);
		int passes;
		passes = 0;
		while (!last_expect.search_over && passes < pass_cap) begin
			run_pass(conflict_pct);
			passes++;
		end
	endtask

	task automatic enumerate_bus(input int conflict_pct);
		send_event(make_event(OP_BEGIN, coin(), coin(), coin(), coin()));
		search_passes(conflict_pct, 64);
	endtask

	// reset leaves the search finished: everything but begin is ignored
	task automatic test_idle_events();
		send_event(make_event(OP_PRESENCE, 1'b1, 1'b0, 1'b0, 1'b0));
		send_event(make_event(OP_TRIPLET, 1'b0, 1'b1, 1'b1, 1'b1));
		send_event(make_event(OP_UNDEFINED, 1'b1, 1'b1, 1'b1, 1'b1));
	endtask

	task automatic test_zero_limit();
		set_limit(8'd0);
		send_event(make_event(OP_BEGIN, 1'b0, 1'b0, 1'b0, 1'b0));
		send_event(make_event(OP_PRESENCE, 1'b1, 1'b0, 1'b0, 1'b0));
	endtask

	// out-of-order events, restarts mid pass, and three conflicts in a row
	task automatic test_pass_control();
		set_limit(8'd255);
		send_event(make_event(OP_BEGIN, 1'b1, 1'b1, 1'b1, 1'b1));
		send_event(make_event(OP_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b1));
		send_event(make_event(OP_UNDEFINED, 1'b0, 1'b0, 1'b0, 1'b0));
		send_event(make_event(OP_PRESENCE, 1'b1, 1'b1, 1'b1, 1'b1));
		send_event(make_event(OP_TRIPLET, 1'b1, 1'b1, 1'b0, 1'b1));
		send_event(make_event(OP_TRIPLET, 1'b0, 1'b0, 1'b1, 1'b0));
		send_event(make_event(OP_TRIPLET, 1'b0, 1'b1, 1'b1, 1'b0));
		send_event(make_event(OP_PRESENCE, 1'b1, 1'b0, 1'b0, 1'b0));
		send_event(make_event(OP_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b0));
		send_event(make_event(OP_TRIPLET, 1'b1, 1'b1, 1'b1, 1'b1));
		send_event(make_event(OP_PRESENCE, 1'b1, 1'b0, 1'b0, 1'b0));
		send_event(make_event(OP_TRIPLET, 1'b0, 1'b1, 1'b1, 1'b0));
		send_event(make_event(OP_PRESENCE, 1'b0, 1'b0, 1'b0, 1'b0));
		send_event(make_event(OP_BEGIN, 1'b0, 1'b0, 1'b0, 1'b0));
		send_event(make_event(OP_PRESENCE, 1'b0, 1'b1, 1'b1, 1'b1));
		send_event(make_event(OP_UNDEFINED, 1'b0, 1'b0, 1'b0, 1'b0));
	endtask

	task automatic test_single_devices();
		set_limit(8'd16);
		bus_ids = '{64'hFFFF_FFFF_FFFF_FFFF};
		enumerate_bus(0);
		set_limit(8'd1);
		bus_ids = '{64'h0};
		enumerate_bus(0);
	endtask

	// limit dropped below the count already found, mid search
	task automatic test_lowered_limit();
		set_limit(8'd255);
		load_bus(5);
		send_event(make_event(OP_BEGIN, 1'b0, 1'b0, 1'b0, 1'b0));
		search_passes(0, 2);
		set_limit(8'd1);
		search_passes(0, 64);
	endtask

	task automatic test_random_searches();
		int r;
		while (events_sent < SEARCH_TARGET) begin
			load_bus($urandom_range(1, 6));
			r = $urandom_range(0, 9);
			if (r < 6)
				set_limit(8'd255);
			else if (r < 8)
				set_limit(8'($urandom_range(1, 4)));
			else if (r == 8)
				set_limit(8'd1);
			else
				set_limit(8'($urandom_range(5, 254)));
			enumerate_bus(($urandom_range(0, 3) == 0) ? 40 : 5);
		end
	endtask

	task automatic test_broken_sequences();
		int pick;
		set_limit(8'd255);
		repeat (150) begin
			pick = $urandom_range(0, 19);
			if (pick < 2)
				send_event(make_event(OP_BEGIN, coin(), coin(), coin(), coin()));
			else if (pick < 7)
				send_event(make_event(OP_PRESENCE, 1'($urandom_range(0, 7) != 0),
				                      coin(), coin(), coin()));
			else if (pick < 18)
				send_event(make_event(OP_TRIPLET, coin(), coin(), coin(), coin()));
			else
				send_event(make_event(OP_UNDEFINED, coin(), coin(), coin(), coin()));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_idle_events();
		test_zero_limit();
		test_pass_control();
		test_single_devices();
		test_lowered_limit();
		test_random_searches();
		test_broken_sequences();
		wait_quiet();
		if (mismatches == 0 && search_results.size() == 0)
			$display("PASS one_wire_rom_search_unit");
		else
			$display("FAIL one_wire_rom_search_unit");
		$finish;
	end

endmodule
